// ----- sv/alarm_severity_latch_assert.svh -----
// Assertion macros shared by the alarm severity latch modules.
`ifndef ALARM_SEVERITY_LATCH_ASSERT_SVH
`define ALARM_SEVERITY_LATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ASL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm latch check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm latch check failed: next-cycle implication");

`endif

// ----- sv/asl_pkg.sv -----
package asl_pkg;

    // Width of a message tag.
    localparam int MESSAGE_TAG_WIDTH = 16;

    // Severity and status codes.
    localparam logic [2:0] SEV_INVALID = 3'd3;
    localparam logic [4:0] STAT_LINK   = 5'd14;

    // Event mask bits.
    localparam logic [1:0] EVT_VALUE = 2'b01;
    localparam logic [1:0] EVT_ALARM = 2'b10;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_REPORT    = 2'd0,
        OP_INHERIT   = 2'd1,
        OP_COMMIT    = 2'd2,
        OP_LINK_FAIL = 2'd3
    } t_op;

    // Inherit modes.
    typedef enum logic [1:0] {
        INH_NONE    = 2'd0,
        INH_ALWAYS  = 2'd1,
        INH_INVALID = 2'd2,
        INH_STATUS  = 2'd3
    } t_inherit;

    // One input item.
    typedef struct packed {
        t_op                            operation;
        logic [4:0]                     status;
        logic [2:0]                     severity;
        logic [MESSAGE_TAG_WIDTH-1:0]   message_tag;
        t_inherit                       inherit_mode;
    } t_item;

    // One result item.
    typedef struct packed {
        logic       report_taken;
        logic       alarm_changed;
        logic [1:0] status_events;
        logic       severity_event;
        logic       ack_event;
        logic [1:0] previous_severity;
        logic [4:0] previous_status;
        logic [1:0] current_severity;
        logic [4:0] current_status;
        logic [1:0] ack_level;
    } t_result;

endpackage

// ----- sv/asl_in_if.sv -----
interface asl_in_if;
    import asl_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [1:0]                     operation;
    logic [4:0]                     status;
    logic [2:0]                     severity;
    logic [MESSAGE_TAG_WIDTH-1:0]   message_tag;
    logic [1:0]                     inherit_mode;

    modport source (
        output valid, operation, status, severity, message_tag, inherit_mode,
        input  ready
    );

    modport sink (
        input  valid, operation, status, severity, message_tag, inherit_mode,
        output ready
    );

endinterface

// ----- sv/asl_out_if.sv -----
interface asl_out_if;

    logic       valid;
    logic       ready;
    logic       report_taken;
    logic       alarm_changed;
    logic [1:0] status_events;
    logic       severity_event;
    logic       ack_event;
    logic [1:0] previous_severity;
    logic [4:0] previous_status;
    logic [1:0] current_severity;
    logic [4:0] current_status;
    logic [1:0] ack_level;

    modport source (
        output valid, report_taken, alarm_changed, status_events, severity_event,
               ack_event, previous_severity, previous_status, current_severity,
               current_status, ack_level,
        input  ready
    );

    modport sink (
        input  valid, report_taken, alarm_changed, status_events, severity_event,
               ack_event, previous_severity, previous_status, current_severity,
               current_status, ack_level,
        output ready
    );

endinterface

// ----- sv/asl_core.sv -----
`include "alarm_severity_latch_assert.svh"

module asl_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    input  logic            i_fire,
    input  asl_pkg::t_item  i_item,
    output asl_pkg::t_result o_result
);
    import asl_pkg::*;

    // Alarm state of the record.
    logic [4:0]                     r_comm_status,  n_comm_status;
    logic [1:0]                     r_comm_sev,     n_comm_sev;
    logic [4:0]                     r_pend_status,  n_pend_status;
    logic [2:0]                     r_pend_sev,     n_pend_sev;
    logic [MESSAGE_TAG_WIDTH-1:0]   r_pend_msg,     n_pend_msg;
    logic [MESSAGE_TAG_WIDTH-1:0]   r_comm_msg,     n_comm_msg;
    logic [1:0]                     r_ack_sev,      n_ack_sev;
    logic                           r_ack_transient;

    // Candidate offered to the pending slot.
    logic                           cand_en;
    logic [4:0]                     cand_status;
    logic [MESSAGE_TAG_WIDTH-1:0]   cand_msg;
    logic                           taken;

    // Commit evaluation.
    logic [1:0]                     new_sev;
    logic                           msg_diff;
    logic                           sev_diff;
    logic                           st_diff;
    logic [1:0]                     events;

    // Select the candidate for a report or an inherited alarm.
    always_comb begin
        cand_en     = 1'b0;
        cand_status = i_item.status;
        cand_msg    = '0;
        case (i_item.operation)
            OP_REPORT: begin
                cand_en  = 1'b1;
                cand_msg = i_item.message_tag;
            end
            OP_INHERIT: begin
                if (i_item.inherit_mode == INH_ALWAYS ||
                    (i_item.inherit_mode == INH_INVALID &&
                     i_item.severity >= SEV_INVALID)) begin
                    cand_en     = 1'b1;
                    cand_status = STAT_LINK;
                end else if (i_item.inherit_mode == INH_STATUS) begin
                    cand_en = 1'b1;
                end
            end
            default: begin
                cand_en = 1'b0;
            end
        endcase
        taken = cand_en && (r_pend_sev < i_item.severity);
    end

    // Compare the pending alarm with the committed one.
    always_comb begin
        new_sev  = (r_pend_sev > SEV_INVALID) ? SEV_INVALID[1:0] : r_pend_sev[1:0];
        msg_diff = (r_pend_msg != r_comm_msg);
        sev_diff = (new_sev != r_comm_sev);
        st_diff  = (r_pend_status != r_comm_status);
        events   = ((msg_diff || sev_diff) ? EVT_ALARM : 2'b00) |
                   (st_diff ? EVT_VALUE : 2'b00);
    end

    // Next state and the result of the current item.
    always_comb begin
        n_comm_status = r_comm_status;
        n_comm_sev    = r_comm_sev;
        n_pend_status = r_pend_status;
        n_pend_sev    = r_pend_sev;
        n_pend_msg    = r_pend_msg;
        n_comm_msg    = r_comm_msg;
        n_ack_sev     = r_ack_sev;
        o_result      = '0;

        o_result.previous_severity = r_comm_sev;
        o_result.previous_status   = r_comm_status;

        unique case (i_item.operation)
            OP_REPORT, OP_INHERIT: begin
                o_result.report_taken = taken;
                if (taken) begin
                    n_pend_status = cand_status;
                    n_pend_sev    = i_item.severity;
                    n_pend_msg    = cand_msg;
                end
            end
            OP_COMMIT: begin
                n_comm_status = r_pend_status;
                n_comm_sev    = new_sev;
                n_comm_msg    = r_pend_msg;
                n_pend_status = '0;
                n_pend_sev    = '0;
                o_result.status_events  = events;
                o_result.severity_event = sev_diff;
                o_result.alarm_changed  = (events != 2'b00);
                if ((events != 2'b00) && (!r_ack_transient || new_sev >= r_ack_sev)) begin
                    n_ack_sev          = new_sev;
                    o_result.ack_event = 1'b1;
                end
            end
            OP_LINK_FAIL: begin
                if (r_pend_sev == 3'd0) begin
                    n_pend_status = STAT_LINK;
                end
            end
        endcase

        o_result.current_severity = n_comm_sev;
        o_result.current_status   = n_comm_status;
        o_result.ack_level        = n_ack_sev;
    end

    // State registers, updated as each item leaves for the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comm_status   <= '0;
            r_comm_sev      <= '0;
            r_pend_status   <= '0;
            r_pend_sev      <= '0;
            r_pend_msg      <= '0;
            r_comm_msg      <= '0;
            r_ack_sev       <= '0;
            r_ack_transient <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ack_transient <= i_cfg_data;
            end
            if (i_fire) begin
                r_comm_status <= n_comm_status;
                r_comm_sev    <= n_comm_sev;
                r_pend_status <= n_pend_status;
                r_pend_sev    <= n_pend_sev;
                r_pend_msg    <= n_pend_msg;
                r_comm_msg    <= n_comm_msg;
                r_ack_sev     <= n_ack_sev;
            end
        end
    end

    // A commit leaves nothing pending.
    `ASL_ASSERT_NEXT(a_commit_clears, i_clk, i_rst_n,
        i_fire && i_item.operation == OP_COMMIT,
        r_pend_sev == 3'd0 && r_pend_status == 5'd0)

    // Pending severity only falls through a commit.
    `ASL_ASSERT_NEXT(a_pend_monotonic, i_clk, i_rst_n,
        i_fire && i_item.operation != OP_COMMIT && !i_cfg_we,
        r_pend_sev >= $past(r_pend_sev))

    // The acknowledge severity only moves with a commit that changed the alarm.
    `ASL_ASSERT_NEXT(a_ack_on_change, i_clk, i_rst_n,
        !(i_fire && i_item.operation == OP_COMMIT && events != 2'b00),
        $stable(r_ack_sev))

endmodule

// ----- sv/alarm_severity_latch.sv -----
// Alarm severity latch for one record.
// Input channel i_item carries one transaction per operation: report, inherit,
// commit or link read failure, with status, severity, message tag and inherit
// mode. Output channel o_result returns exactly one transaction per input
// transaction, in order, with the event flags and the committed alarm before
// and after that operation. The ack_transient register is written through
// i_cfg_we and i_cfg_data; the user must write it only while the block is idle,
// as the block does not enforce this. An accepted transaction goes from the
// input register through evaluation into the result register, which drives
// o_result. Throughput is one transaction per cycle while the receiver does not
// stall; the limit is the single stage that reads and updates the alarm state.
// Reset clears all alarm state, the register and both pipeline stages.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more; i_item.ready then falls until the
// result is taken, so no transaction is lost.
module alarm_severity_latch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    asl_in_if.sink      i_item,
    asl_out_if.source   o_result
);
    import asl_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result eval_result;
    logic    fire;

    // The evaluation stage moves on when the result register is free or drained.
    assign fire         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || fire;

    asl_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (r_in),
        .o_result   (eval_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.operation    <= t_op'(i_item.operation);
            r_in.status       <= i_item.status;
            r_in.severity     <= i_item.severity;
            r_in.message_tag  <= i_item.message_tag;
            r_in.inherit_mode <= t_inherit'(i_item.inherit_mode);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= eval_result;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.report_taken      = r_out.report_taken;
    assign o_result.alarm_changed     = r_out.alarm_changed;
    assign o_result.status_events     = r_out.status_events;
    assign o_result.severity_event    = r_out.severity_event;
    assign o_result.ack_event         = r_out.ack_event;
    assign o_result.previous_severity = r_out.previous_severity;
    assign o_result.previous_status   = r_out.previous_status;
    assign o_result.current_severity  = r_out.current_severity;
    assign o_result.current_status    = r_out.current_status;
    assign o_result.ack_level         = r_out.ack_level;

    // An acknowledge update only comes with a changed alarm.
    `ASL_ASSERT_SAME(a_ack_needs_change, i_clk, i_rst_n,
        r_out_valid && r_out.ack_event,
        r_out.alarm_changed)

    // A severity event always raises the alarm event bit.
    `ASL_ASSERT_SAME(a_sev_event_alarm, i_clk, i_rst_n,
        r_out_valid && r_out.severity_event,
        r_out.status_events[1] && r_out.current_severity != r_out.previous_severity)

    // A full pipeline blocked at the output accepts nothing.
    `ASL_ASSERT_SAME(a_full_stall, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_result.ready,
        !i_item.ready)

endmodule
